### rtl/hbs_pkg.sv
// Package for the 3D binary-search-binning histogram.
// Holds command and register codes, stream field offsets and sizing helpers.
// No dependencies; every other file imports it.
package hbs_pkg;

    localparam int MAX_EDGES_DEF   = 17;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam logic [4:0] EDGES_USED_RESET = 5'd17;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] CFG_EDGES_X = 2'd0;
    localparam logic [1:0] CFG_EDGES_Y = 2'd1;
    localparam logic [1:0] CFG_EDGES_Z = 2'd2;

    // Input stream payload layout, lowest bit first.
    localparam int S_TDATA_W  = 152;
    localparam int OFS_AXIS   = 0;
    localparam int OFS_SLOT   = 2;
    localparam int OFS_EVAL   = 7;
    localparam int OFS_SX     = 39;
    localparam int OFS_SY     = 71;
    localparam int OFS_SZ     = 103;
    localparam int OFS_RBX    = 135;
    localparam int OFS_RBY    = 139;
    localparam int OFS_RBZ    = 143;

    // Output stream payload layout, lowest bit first.
    localparam int M_TDATA_W  = 48;

    // Address width for a store of n entries, never below one bit.
    function automatic int bits_for(input int n);
        int w;
        w = $clog2(n);
        return (w < 1) ? 1 : w;
    endfunction

    typedef struct packed {
        logic capture;
        logic edge_we;
        logic scan_step;
        logic calc;
        logic cnt_upd;
        logic clr_step;
        logic out_load;
    } hbs_ctl_t;

    typedef struct packed {
        logic scan_last;
        logic clr_last;
    } hbs_sts_t;

endpackage

### rtl/histogram_3d_binary_search_binning.sv
// 3D histogram with per-axis edge tables and saturating bin counts.
// Bin sample: the three axes scan their edge RAMs in parallel, one edge per cycle,
// then one count RMW, then the result loads and m_tvalid rises.
// Read count, load edge and clear (a sweep of all NBINS^3 counts) end the same way.
// s_tready returns the cycle after the result loads; no new transaction is taken before.
// After reset a sweep zeroes the count RAM with s_tready low.
module histogram_3d_binary_search_binning import hbs_pkg::*; #(
    parameter int MAX_EDGES   = MAX_EDGES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // s_tdata: axis_select[1:0], edge_slot[6:2], edge_value[38:7],
    // sample_x[70:39], sample_y[102:71], sample_z[134:103],
    // read_bin_x[138:135], read_bin_y[142:139], read_bin_z[146:143], zeros above.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: cmd[1:0].
    input  logic [1:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // m_tdata: found_bin_x[3:0], found_bin_y[7:4], found_bin_z[11:8],
    // count_value[43:12], zeros above.
    output logic [M_TDATA_W-1:0] m_tdata,
    // m_tuser: in_range[0].
    output logic                 m_tuser,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [4:0]           cfg_wdata
);

    hbs_ctl_t ctl;
    hbs_sts_t sts;
    cmd_t     s_cmd;

    assign s_cmd = cmd_t'(s_tuser);

    hbs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_cmd    (s_cmd),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    hbs_dpath #(
        .MAX_EDGES   (MAX_EDGES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_cmd     (s_cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### rtl/hbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on hbs_pkg for the address width helper.
// Contents are not reset.
module hbs_ram import hbs_pkg::*; #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [bits_for(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]           wdata,
    input  logic [bits_for(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/hbs_axis.sv
// One axis of the binning datapath: the edge table RAM and the scan that
// finds the lowest bin j with edge[j] < value <= edge[j+1].
// Depends on hbs_pkg and hbs_ram.
module hbs_axis import hbs_pkg::*; #(
    parameter int MAX_EDGES = MAX_EDGES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               edge_we,
    input  logic [bits_for(MAX_EDGES)-1:0]     edge_waddr,
    input  logic signed [31:0]                 edge_wdata,
    input  logic [bits_for(MAX_EDGES)-1:0]     raddr,
    input  logic                               rd_valid,
    input  logic [bits_for(MAX_EDGES)-1:0]     rd_idx,
    input  logic signed [31:0]                 value,
    input  logic [4:0]                         n_used,
    output logic                               hit,
    output logic [bits_for(MAX_EDGES-1)-1:0]   bin
);

    localparam int EW = bits_for(MAX_EDGES);
    localparam int BW = bits_for(MAX_EDGES - 1);

    logic [31:0]        ram_q;
    logic signed [31:0] edge_rd;
    logic signed [31:0] e0_reg;
    logic signed [31:0] prev_reg;
    logic [BW-1:0]      bin_reg;
    logic               found_reg;
    logic               hi_ok_reg;
    int                 n_eff;
    logic               in_use;
    logic               is_last;

    hbs_ram #(
        .WIDTH (32),
        .DEPTH (MAX_EDGES)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (raddr),
        .rdata (ram_q)
    );

    assign edge_rd = ram_q;

    always_comb
    begin
        n_eff   = (int'(n_used) > MAX_EDGES) ? MAX_EDGES : int'(n_used);
        in_use  = int'(rd_idx) < n_eff;
        is_last = int'(rd_idx) == (n_eff - 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            hi_ok_reg <= 1'b0;
        end
        else if (start)
        begin
            found_reg <= 1'b0;
            hi_ok_reg <= 1'b0;
        end
        else if (rd_valid)
        begin
            if ((rd_idx != '0) && in_use && !found_reg && (prev_reg < value)
                && (value <= edge_rd))
            begin
                found_reg <= 1'b1;
            end
            if (is_last)
            begin
                hi_ok_reg <= (value <= edge_rd);
            end
        end
    end

    // Edges stream in ascending slot order, one per cycle.
    always_ff @(posedge clk)
    begin
        if (rd_valid)
        begin
            prev_reg <= edge_rd;
            if (rd_idx == '0)
            begin
                e0_reg <= edge_rd;
            end
            else if (in_use && !found_reg && (prev_reg < value) && (value <= edge_rd))
            begin
                bin_reg <= BW'(rd_idx - EW'(1));
            end
        end
    end

    assign hit = (n_used >= 5'd2) && found_reg && hi_ok_reg && (value > e0_reg);
    assign bin = bin_reg;

endmodule

### rtl/hbs_ctrl.sv
// Controller of the histogram: sequences edge loads, the edge scan, the
// count read-modify-write, the clearing sweep and the output register.
// Depends on hbs_pkg.
module hbs_ctrl import hbs_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    input  cmd_t     s_cmd,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    input  hbs_sts_t sts,
    output hbs_ctl_t ctl
);

    typedef enum logic [9:0] {
        ST_INIT  = 10'b00_0000_0001,
        ST_IDLE  = 10'b00_0000_0010,
        ST_LOAD  = 10'b00_0000_0100,
        ST_SCAN  = 10'b00_0000_1000,
        ST_DRAIN = 10'b00_0001_0000,
        ST_CALC  = 10'b00_0010_0000,
        ST_RD    = 10'b00_0100_0000,
        ST_UPD   = 10'b00_1000_0000,
        ST_CLR   = 10'b01_0000_0000,
        ST_DONE  = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    ctl.capture = 1'b1;
                    unique case (s_cmd)
                        CMD_LOAD:   state_next = ST_LOAD;
                        CMD_SAMPLE: state_next = ST_SCAN;
                        CMD_READ:   state_next = ST_CALC;
                        CMD_CLEAR:  state_next = ST_CLR;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:
            begin
                ctl.edge_we = 1'b1;
                state_next  = ST_DONE;
            end
            ST_SCAN:
            begin
                ctl.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                ctl.calc   = 1'b1;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                ctl.cnt_upd = 1'b1;
                state_next  = ST_DONE;
            end
            ST_CLR:
            begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

endmodule

### rtl/hbs_dpath.sv
// Datapath of the histogram: captured transaction, configuration registers,
// three axis scan units, the count store and the result registers.
// Depends on hbs_pkg, hbs_ram and hbs_axis.
module hbs_dpath import hbs_pkg::*; #(
    parameter int MAX_EDGES   = MAX_EDGES_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hbs_ctl_t             ctl,
    output hbs_sts_t             sts,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  cmd_t                 s_cmd,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [4:0]           cfg_wdata,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tuser
);

    localparam int NBINS   = MAX_EDGES - 1;
    localparam int NCOUNTS = NBINS * NBINS * NBINS;
    localparam int EW      = bits_for(MAX_EDGES);
    localparam int BW      = bits_for(NBINS);
    localparam int AW      = bits_for(NCOUNTS);
    localparam int IW      = (BW > 4) ? BW : 4;
    localparam int CW      = COUNT_WIDTH;
    localparam int XW      = COUNT_WIDTH + 32;

    // Captured transaction.
    cmd_t               cmd_reg;
    logic [1:0]         axis_reg;
    logic [4:0]         slot_reg;
    logic signed [31:0] eval_reg;
    logic signed [31:0] sx_reg;
    logic signed [31:0] sy_reg;
    logic signed [31:0] sz_reg;
    logic [3:0]         rbx_reg;
    logic [3:0]         rby_reg;
    logic [3:0]         rbz_reg;

    logic [4:0]         used_x_reg;
    logic [4:0]         used_y_reg;
    logic [4:0]         used_z_reg;

    logic [EW-1:0]      scan_cnt_reg;
    logic               rd_valid_reg;
    logic [EW-1:0]      rd_idx_reg;
    logic [AW-1:0]      clr_addr_reg;

    logic               hit_x;
    logic               hit_y;
    logic               hit_z;
    logic [BW-1:0]      bin_x;
    logic [BW-1:0]      bin_y;
    logic [BW-1:0]      bin_z;
    logic               slot_ok;

    logic [IW-1:0]      ix;
    logic [IW-1:0]      iy;
    logic [IW-1:0]      iz;
    logic               sel_ok;
    logic [AW-1:0]      addr_calc;
    logic [AW-1:0]      addr_reg;
    logic               ok_reg;
    logic [3:0]         fbx_reg;
    logic [3:0]         fby_reg;
    logic [3:0]         fbz_reg;

    logic [CW-1:0]      cnt_q;
    logic [CW-1:0]      cnt_inc;
    logic [CW-1:0]      cnt_sel;
    logic               cnt_we;
    logic [AW-1:0]      cnt_waddr;
    logic [CW-1:0]      cnt_wdata;
    logic [31:0]        cnt_out;

    logic               res_inr_reg;
    logic [3:0]         res_bx_reg;
    logic [3:0]         res_by_reg;
    logic [3:0]         res_bz_reg;
    logic [31:0]        res_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= s_cmd;
            axis_reg <= s_tdata[OFS_AXIS +: 2];
            slot_reg <= s_tdata[OFS_SLOT +: 5];
            eval_reg <= s_tdata[OFS_EVAL +: 32];
            sx_reg   <= s_tdata[OFS_SX +: 32];
            sy_reg   <= s_tdata[OFS_SY +: 32];
            sz_reg   <= s_tdata[OFS_SZ +: 32];
            rbx_reg  <= s_tdata[OFS_RBX +: 4];
            rby_reg  <= s_tdata[OFS_RBY +: 4];
            rbz_reg  <= s_tdata[OFS_RBZ +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_x_reg <= EDGES_USED_RESET;
            used_y_reg <= EDGES_USED_RESET;
            used_z_reg <= EDGES_USED_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_EDGES_X: used_x_reg <= cfg_wdata;
                CFG_EDGES_Y: used_y_reg <= cfg_wdata;
                CFG_EDGES_Z: used_z_reg <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    // Scan and sweep counters wrap to zero after their last step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            rd_valid_reg <= 1'b0;
            clr_addr_reg <= '0;
        end
        else
        begin
            rd_valid_reg <= ctl.scan_step;
            if (ctl.scan_step)
            begin
                scan_cnt_reg <= sts.scan_last ? '0 : scan_cnt_reg + EW'(1);
            end
            if (ctl.clr_step)
            begin
                clr_addr_reg <= sts.clr_last ? '0 : clr_addr_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= scan_cnt_reg;
    end

    assign sts.scan_last = (scan_cnt_reg == EW'(MAX_EDGES - 1));
    assign sts.clr_last  = (clr_addr_reg == AW'(NCOUNTS - 1));

    assign slot_ok = int'(slot_reg) < MAX_EDGES;

    hbs_axis #(.MAX_EDGES (MAX_EDGES)) u_axis_x (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (ctl.capture),
        .edge_we    (ctl.edge_we && slot_ok && (axis_reg == AXIS_X)),
        .edge_waddr (EW'(slot_reg)),
        .edge_wdata (eval_reg),
        .raddr      (scan_cnt_reg),
        .rd_valid   (rd_valid_reg),
        .rd_idx     (rd_idx_reg),
        .value      (sx_reg),
        .n_used     (used_x_reg),
        .hit        (hit_x),
        .bin        (bin_x)
    );

    hbs_axis #(.MAX_EDGES (MAX_EDGES)) u_axis_y (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (ctl.capture),
        .edge_we    (ctl.edge_we && slot_ok && (axis_reg == AXIS_Y)),
        .edge_waddr (EW'(slot_reg)),
        .edge_wdata (eval_reg),
        .raddr      (scan_cnt_reg),
        .rd_valid   (rd_valid_reg),
        .rd_idx     (rd_idx_reg),
        .value      (sy_reg),
        .n_used     (used_y_reg),
        .hit        (hit_y),
        .bin        (bin_y)
    );

    hbs_axis #(.MAX_EDGES (MAX_EDGES)) u_axis_z (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (ctl.capture),
        .edge_we    (ctl.edge_we && slot_ok && (axis_reg == AXIS_Z)),
        .edge_waddr (EW'(slot_reg)),
        .edge_wdata (eval_reg),
        .raddr      (scan_cnt_reg),
        .rd_valid   (rd_valid_reg),
        .rd_idx     (rd_idx_reg),
        .value      (sz_reg),
        .n_used     (used_z_reg),
        .hit        (hit_z),
        .bin        (bin_z)
    );

    // Flat count address is x + NBINS * (y + NBINS * z).
    always_comb
    begin
        if (cmd_reg == CMD_SAMPLE)
        begin
            ix     = IW'(bin_x);
            iy     = IW'(bin_y);
            iz     = IW'(bin_z);
            sel_ok = hit_x && hit_y && hit_z;
        end
        else
        begin
            ix     = IW'(rbx_reg);
            iy     = IW'(rby_reg);
            iz     = IW'(rbz_reg);
            sel_ok = (int'(rbx_reg) < NBINS) && (int'(rby_reg) < NBINS)
                     && (int'(rbz_reg) < NBINS);
        end
        addr_calc = AW'(ix) + AW'(NBINS) * AW'(iy) + AW'(NBINS * NBINS) * AW'(iz);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.calc)
        begin
            addr_reg <= addr_calc;
            ok_reg   <= sel_ok;
            fbx_reg  <= 4'(ix);
            fby_reg  <= 4'(iy);
            fbz_reg  <= 4'(iz);
        end
    end

    assign cnt_inc = (cnt_q == '1) ? cnt_q : cnt_q + CW'(1);
    assign cnt_sel = (cmd_reg == CMD_SAMPLE) ? cnt_inc : cnt_q;
    assign cnt_out = (XW'(cnt_sel) > XW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : 32'(cnt_sel);

    assign cnt_we    = ctl.clr_step || (ctl.cnt_upd && ok_reg && (cmd_reg == CMD_SAMPLE));
    assign cnt_waddr = ctl.clr_step ? clr_addr_reg : addr_reg;
    assign cnt_wdata = ctl.clr_step ? '0 : cnt_inc;

    hbs_ram #(
        .WIDTH (CW),
        .DEPTH (NCOUNTS)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (addr_reg),
        .rdata (cnt_q)
    );

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            res_inr_reg <= 1'b0;
            res_bx_reg  <= '0;
            res_by_reg  <= '0;
            res_bz_reg  <= '0;
            res_cnt_reg <= '0;
        end
        else if (ctl.cnt_upd && ok_reg)
        begin
            res_cnt_reg <= cnt_out;
            if (cmd_reg == CMD_SAMPLE)
            begin
                res_inr_reg <= 1'b1;
                res_bx_reg  <= fbx_reg;
                res_by_reg  <= fby_reg;
                res_bz_reg  <= fbz_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            m_tuser <= res_inr_reg;
            m_tdata <= {4'b0, res_cnt_reg, res_bz_reg, res_by_reg, res_bx_reg};
        end
    end

endmodule
